// ===== hdl/bsra_pkg.sv =====
// Shared types and constants of the slab run allocator.
`default_nettype none
package bsra_pkg;

  localparam int NZONES     = 4;
  localparam int ZONE_WORDS = 16;
  localparam int WORD_BITS  = 64;
  localparam int ZW         = 2;
  localparam int GW         = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  localparam logic REG_ZONE_GROUPS = 1'b0;
  localparam logic REG_ZONE_LIMIT  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [10:0] run_len;
    logic [1:0]  zone_id;
    logic [9:0]  first_slab;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  result_zone;
    logic [9:0]  result_offset;
    logic [10:0] zone_free_slabs;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ZONE, S_WORD, S_RUN, S_OPEN, S_MRD, S_MWR, S_FIN, S_RESP
  } state_t;

  typedef enum logic [4:0] {
    C_NONE, C_LOAD, C_NO_SPACE, C_BAD_FREE, C_ZONE_INIT, C_FREE_INIT, C_ZONE_NEXT,
    C_SRCH_INIT, C_HIT_BIG, C_BIG_NEXT, C_HIT_STR, C_RUN_INIT, C_RUN_STEP,
    C_HIT_RUN, C_WORD_NEXT, C_OPEN, C_MARK_READ, C_MARK_WRITE, C_SET_DONE, C_PUSH
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic n_zero;
    logic free_bad;
    logic zone_end;
    logic zone_fit;
    logic big;
    logic big_hit;
    logic more;
    logic straddle_hit;
    logic run_busy;
    logic run_hit;
    logic open_ok;
    logic mark_last;
    logic out_busy;
  } flags_t;

endpackage
`default_nettype wire

// ===== hdl/bsra_in_if.sv =====
// Request channel interface.
`default_nettype none
interface bsra_in_if import bsra_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bsra_out_if.sv =====
// Response channel interface.
`default_nettype none
interface bsra_out_if import bsra_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bsra_cfg_if.sv =====
// Configuration write channel interface.
`default_nettype none
interface bsra_cfg_if import bsra_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       index;
  logic [4:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bsra_ctrl.sv =====
// Sequencing state machine of the slab run allocator.
`default_nettype none
module bsra_ctrl import bsra_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire flags_t flags,
  output cmd_t        cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_START;
      S_START: begin
        if (flags.is_free) begin
          state_next = flags.free_bad ? S_RESP : S_MRD;
        end else begin
          state_next = flags.n_zero ? S_RESP : S_ZONE;
        end
      end
      S_ZONE: begin
        if (flags.zone_end) state_next = S_OPEN;
        else if (flags.zone_fit) state_next = S_WORD;
      end
      S_WORD: begin
        if (flags.big) begin
          if (flags.big_hit) state_next = S_MRD;
          else if (!flags.more) state_next = S_ZONE;
        end else begin
          state_next = flags.straddle_hit ? S_MRD : S_RUN;
        end
      end
      S_RUN: begin
        if (!flags.run_busy) begin
          if (flags.run_hit) state_next = S_MRD;
          else if (flags.more) state_next = S_WORD;
          else state_next = S_ZONE;
        end
      end
      S_OPEN: state_next = flags.open_ok ? S_MRD : S_RESP;
      S_MRD:  state_next = S_MWR;
      S_MWR:  state_next = flags.mark_last ? S_FIN : S_MRD;
      S_FIN:  state_next = S_RESP;
      S_RESP: if (!flags.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = C_NONE;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = C_LOAD;
      end
      S_START: begin
        if (flags.is_free) begin
          cmd = flags.free_bad ? C_BAD_FREE : C_FREE_INIT;
        end else begin
          cmd = flags.n_zero ? C_NO_SPACE : C_ZONE_INIT;
        end
      end
      S_ZONE: begin
        if (flags.zone_end) cmd = C_NONE;
        else if (flags.zone_fit) cmd = C_SRCH_INIT;
        else cmd = C_ZONE_NEXT;
      end
      S_WORD: begin
        if (flags.big) begin
          if (flags.big_hit) cmd = C_HIT_BIG;
          else if (flags.more) cmd = C_BIG_NEXT;
          else cmd = C_ZONE_NEXT;
        end else begin
          cmd = flags.straddle_hit ? C_HIT_STR : C_RUN_INIT;
        end
      end
      S_RUN: begin
        if (flags.run_busy) cmd = C_RUN_STEP;
        else if (flags.run_hit) cmd = C_HIT_RUN;
        else if (flags.more) cmd = C_WORD_NEXT;
        else cmd = C_ZONE_NEXT;
      end
      S_OPEN: cmd = flags.open_ok ? C_OPEN : C_NO_SPACE;
      S_MRD:  cmd = C_MARK_READ;
      S_MWR:  cmd = C_MARK_WRITE;
      S_FIN:  cmd = C_SET_DONE;
      S_RESP: if (!flags.out_busy) cmd = C_PUSH;
      default: cmd = C_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/bsra_dp.sv =====
// Datapath: bitmap memory, zone bookkeeping, run search and marking.
`default_nettype none
module bsra_dp import bsra_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t in_data,
  input  wire cmd_t     cmd,
  output flags_t        flags,
  bsra_cfg_if.sink      cfg_ch,
  bsra_out_if.source    out_ch
);

  localparam int DEPTH = NZONES * ZONE_WORDS;
  localparam int AW    = ZW + GW;
  localparam logic [WORD_BITS-1:0] ONES = '1;

  function automatic logic [6:0] lzc(input logic [WORD_BITS-1:0] v);
    logic [6:0] r;
    r = 7'd64;
    for (int i = 0; i < WORD_BITS; i++) if (v[i]) r = 7'(63 - i);
    return r;
  endfunction

  function automatic logic [6:0] tzc(input logic [WORD_BITS-1:0] v);
    logic [6:0] r;
    r = 7'd64;
    for (int i = WORD_BITS - 1; i >= 0; i--) if (v[i]) r = 7'(i);
    return r;
  endfunction

  function automatic logic [GW-1:0] tzc16(input logic [ZONE_WORDS-1:0] v);
    logic [GW-1:0] r;
    r = '0;
    for (int i = ZONE_WORDS - 1; i >= 0; i--) if (v[i]) r = GW'(i);
    return r;
  endfunction

  function automatic logic [6:0] popc(input logic [WORD_BITS-1:0] v);
    logic [6:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) r = r + 7'(v[i]);
    return r;
  endfunction

  function automatic logic [ZONE_WORDS-1:0] gmask(input logic [4:0] c);
    logic [ZONE_WORDS:0] t;
    t = (17'd1 << c) - 17'd1;
    return t[ZONE_WORDS-1:0];
  endfunction

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     vld;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rdv_q;
  logic [AW-1:0]        rd_addr;

  logic [10:0] fc    [NZONES];
  logic [15:0] full  [NZONES];
  logic [15:0] empt  [NZONES];
  logic [4:0]  cnt   [NZONES];
  logic [2:0]  zopen;
  logic [4:0]  zone_groups;
  logic [2:0]  zone_limit;

  logic        op_r;
  logic [10:0] n_r;
  logic [1:0]  zid_r;
  logic [9:0]  off_r;
  logic [2:0]  z;
  logic [GW-1:0] g;
  logic        have_prev;
  logic [6:0]  lz_prev;
  logic        chain_act;
  logic [10:0] chain_pos;
  logic [10:0] total;
  logic [WORD_BITS-1:0] bits;
  logic [6:0]  len;
  out_item_t   res;

  logic [ZW-1:0] zi;
  logic [WORD_BITS-1:0] w, m, new_w;
  logic [6:0]  lz_w, tz_w, pc, tz_bits;
  logic [4:0]  cnt_z;
  logic [15:0] open_m;
  logic [GW-1:0] g0;
  logic [10:0] t2, restart_pos;
  logic [11:0] end_sum;
  logic [5:0]  lo, hi;
  logic [4:0]  zg_eff;
  logic [2:0]  zl_eff;
  logic [5:0]  s_half;

  assign zi      = z[ZW-1:0];
  assign w       = rdv_q ? rd_q : '0;
  assign lz_w    = lzc(w);
  assign tz_w    = tzc(w);
  assign tz_bits = tzc(bits);
  assign cnt_z   = cnt[zi];
  assign open_m  = ~full[zi] & gmask(cnt_z);
  assign g0      = tzc16(open_m);
  assign t2      = total + {4'b0, tz_w};
  assign restart_pos = {1'b0, g, 6'b0} + 11'd64 - {4'b0, lz_w};
  assign end_sum = {2'b0, off_r} + {1'b0, n_r} - 12'd1;
  assign lo      = (g == off_r[9:6]) ? off_r[5:0] : 6'd0;
  assign hi      = flags.mark_last ? end_sum[5:0] : 6'd63;
  assign m       = (ONES << lo) & (ONES >> (6'd63 - hi));
  assign new_w   = (op_r == OP_FREE) ? (w & ~m) : (w | m);
  assign pc      = popc((op_r == OP_FREE) ? (m & w) : (m & ~w));
  assign zg_eff  = (zone_groups == 5'd0) ? 5'd1 :
                   (zone_groups > 5'(ZONE_WORDS)) ? 5'(ZONE_WORDS) : zone_groups;
  assign zl_eff  = (zone_limit > 3'(NZONES)) ? 3'(NZONES) : zone_limit;
  assign s_half  = len[6:1];

  always_comb begin
    flags.is_free      = (op_r == OP_FREE);
    flags.n_zero       = (n_r == 11'd0);
    flags.free_bad     = (n_r == 11'd0) || ({1'b0, zid_r} >= zopen) ||
                         (({2'b0, off_r} + {1'b0, n_r}) > {1'b0, cnt[zid_r], 6'b0});
    flags.zone_end     = (z >= zopen);
    flags.zone_fit     = (fc[zi] >= n_r) && (open_m != '0);
    flags.big          = (n_r > 11'd64);
    flags.big_hit      = chain_act && (t2 >= n_r);
    flags.more         = (({1'b0, g} + 5'd1) < cnt_z);
    flags.straddle_hit = have_prev && (({4'b0, lz_prev} + {4'b0, tz_w}) >= n_r);
    flags.run_busy     = (len > 7'd1);
    flags.run_hit      = (bits != '0);
    flags.open_ok      = (zopen < zl_eff) && (n_r <= {zg_eff, 6'b0});
    flags.mark_last    = (g == end_sum[9:6]);
    flags.out_busy     = out_ch.valid && !out_ch.ready;
  end

  always_comb begin
    case (cmd)
      C_SRCH_INIT:              rd_addr = {zi, g0};
      C_WORD_NEXT, C_BIG_NEXT:  rd_addr = {zi, g + GW'(1)};
      default:                  rd_addr = {zi, g};
    endcase
  end

  always_ff @(posedge clk) begin
    rd_q  <= mem[rd_addr];
    rdv_q <= vld[rd_addr];
    if (cmd == C_MARK_WRITE) mem[{zi, g}] <= new_w;
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      zopen        <= '0;
      zone_groups  <= 5'd16;
      zone_limit   <= 3'd4;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < NZONES; i++) begin
        fc[i]   <= '0;
        full[i] <= '0;
        empt[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_ZONE_GROUPS: zone_groups <= cfg_ch.data;
          REG_ZONE_LIMIT:  zone_limit  <= cfg_ch.data[2:0];
          default: ;
        endcase
      end
      if (cmd == C_PUSH) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (cmd)
        C_OPEN: begin
          zopen        <= zopen + 3'd1;
          cnt[zopen[ZW-1:0]]  <= zg_eff;
          fc[zopen[ZW-1:0]]   <= {zg_eff, 6'b0};
          full[zopen[ZW-1:0]] <= '0;
          empt[zopen[ZW-1:0]] <= gmask(zg_eff);
        end
        C_MARK_WRITE: begin
          vld[{zi, g}] <= 1'b1;
          fc[zi]       <= (op_r == OP_FREE) ? fc[zi] + {4'b0, pc} : fc[zi] - {4'b0, pc};
          full[zi][g]  <= (new_w == ONES);
          empt[zi][g]  <= (new_w == '0);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      C_LOAD: begin
        op_r  <= in_data.operation;
        n_r   <= in_data.run_len;
        zid_r <= in_data.zone_id;
        off_r <= in_data.first_slab;
      end
      C_NO_SPACE: res <= '{ST_NO_SPACE, 2'd0, 10'd0, 11'd0};
      C_BAD_FREE: res <= '{ST_BAD_FREE, 2'd0, 10'd0, 11'd0};
      C_ZONE_INIT: z <= '0;
      C_FREE_INIT: begin
        z <= {1'b0, zid_r};
        g <= off_r[9:6];
      end
      C_ZONE_NEXT: z <= z + 3'd1;
      C_SRCH_INIT: begin
        g         <= g0;
        have_prev <= 1'b0;
        chain_act <= 1'b0;
      end
      C_BIG_NEXT: begin
        g <= g + GW'(1);
        if (!chain_act || (tz_w != 7'd64)) begin
          chain_act <= 1'b1;
          chain_pos <= restart_pos;
          total     <= {4'b0, lz_w};
        end else begin
          total <= t2;
        end
      end
      C_HIT_BIG: begin
        off_r <= chain_pos[9:0];
        g     <= chain_pos[9:6];
      end
      C_HIT_STR: begin
        off_r <= {g, 6'b0} - {3'b0, lz_prev};
        g     <= (lz_prev == 7'd0) ? g : g - GW'(1);
      end
      C_RUN_INIT: begin
        bits    <= ~w;
        len     <= n_r[6:0];
        lz_prev <= lz_w;
      end
      C_RUN_STEP: begin
        bits <= bits & (bits >> s_half);
        len  <= len - {1'b0, s_half};
      end
      C_HIT_RUN: begin
        off_r <= {g, tz_bits[5:0]};
      end
      C_WORD_NEXT: begin
        g         <= g + GW'(1);
        have_prev <= 1'b1;
      end
      C_OPEN: begin
        z     <= zopen;
        off_r <= '0;
        g     <= '0;
      end
      C_MARK_WRITE: g <= g + GW'(1);
      C_SET_DONE: res <= '{ST_DONE, zi, off_r, fc[zi]};
      C_PUSH: out_ch.data <= res;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) zopen <= 3'(NZONES))
    else $error("zone count past its limit");
  assert property (@(posedge clk) disable iff (rst) (full[zi] & empt[zi]) == '0)
    else $error("group flagged both full and empty");
  assert property (@(posedge clk) disable iff (rst) fc[zi] <= {cnt[zi], 6'b0})
    else $error("free count above zone size");
  assert property (@(posedge clk) disable iff (rst)
    (cmd == C_PUSH) |=> out_ch.valid)
    else $error("response not held after push");

endmodule
`default_nettype wire

// ===== hdl/bitmap_slab_run_allocator_unit.sv =====
// Top level of the first-fit slab run allocator.
//
// Channels: in_ch takes requests (allocate or free a run of slabs), out_ch
// returns one response per request, cfg_ch writes zone_groups (index 0) and
// zone_limit (index 1); the user must write these only while the block is
// idle, which the block itself does not enforce. A transfer happens on a
// rising edge with valid and ready high. One request is worked at a time.
// A free marks each touched 64-slab word by a read and a write back. An
// allocation checks the open zones in turn, scanning words for runs over
// 64 slabs or using the halving run search for shorter runs, opens a new
// zone if none fits, then marks each touched word and writes the response.
// The bitmap is a single-port memory of 64 words read one word per cycle.
// Reset empties all zones, closes them and restores zone_groups 16 and
// zone_limit 4; no clearing pass is needed. A stalled receiver holds the
// response in the output register; the next request is still taken and
// worked, and waits for the register before its response is written.
`default_nettype none
module bitmap_slab_run_allocator_unit import bsra_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  bsra_in_if.sink    in_ch,
  bsra_out_if.source out_ch,
  bsra_cfg_if.sink   cfg_ch
);

  flags_t flags;
  cmd_t   cmd;

  bsra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .flags    (flags),
    .cmd      (cmd)
  );

  bsra_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_data (in_ch.data),
    .cmd     (cmd),
    .flags   (flags),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ===== tb/slab_alloc_scoreboard.sv =====
// Scoreboard class: slab run allocator prediction and response checking.
`timescale 1ns / 100ps
`default_nettype none
package slab_alloc_tb_pkg;
  import bsra_pkg::*;

  class slab_alloc_scoreboard;
    logic [63:0] words[NZONES * ZONE_WORDS];
    int unsigned free_slabs[NZONES];
    logic [15:0] full_map[NZONES];
    logic [15:0] empty_map[NZONES];
    int unsigned groups[NZONES];
    int unsigned open_zones;
    int unsigned cfg_groups;
    int unsigned cfg_limit;
    out_item_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < NZONES * ZONE_WORDS; i++) words[i] = '0;
      for (int z = 0; z < NZONES; z++) begin
        free_slabs[z] = 0;
        full_map[z] = '0;
        empty_map[z] = '0;
        groups[z] = 0;
      end
      open_zones = 0;
      cfg_groups = 16;
      cfg_limit = 4;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [4:0] val);
      if (idx == REG_ZONE_GROUPS) cfg_groups = int'(val);
      else cfg_limit = int'(val[2:0]);
    endfunction

    function int unsigned lead0(logic [63:0] w);
      int unsigned n;
      n = 0;
      while (n < 64 && !w[63 - n]) n++;
      return n;
    endfunction

    function int unsigned trail0(logic [63:0] w);
      int unsigned n;
      n = 0;
      while (n < 64 && !w[n]) n++;
      return n;
    endfunction

    function int first_run(logic [63:0] free_bits, int unsigned len);
      int unsigned s;
      while (len > 1) begin
        s = len >> 1;
        free_bits = free_bits & (free_bits >> s);
        len -= s;
      end
      return free_bits != 0 ? int'(trail0(free_bits)) : -1;
    endfunction

    function void set_run(int unsigned z, int unsigned off, int unsigned n, bit used);
      int unsigned lo, hi, len;
      logic [63:0] m, w;
      for (int unsigned g = off / 64; g <= (off + n - 1) / 64; g++) begin
        lo = off > g * 64 ? off - g * 64 : 0;
        hi = off + n < (g + 1) * 64 ? off + n - g * 64 : 64;
        len = hi - lo;
        m = len >= 64 ? '1 : (((64'd1 << len) - 64'd1) << lo);
        w = words[z * ZONE_WORDS + g];
        if (used) begin
          free_slabs[z] -= $countones(m & ~w);
          w |= m;
        end else begin
          free_slabs[z] += $countones(m & w);
          w &= ~m;
        end
        words[z * ZONE_WORDS + g] = w;
        full_map[z][g] = (w == '1);
        empty_map[z][g] = (w == '0);
      end
    endfunction

    function int place_in_zone(int unsigned z, int unsigned n);
      int unsigned cnt, g, top, total, sp;
      logic [15:0] avail;
      logic [63:0] w;
      int s;
      cnt = groups[z];
      avail = ~full_map[z] & ((cnt >= 16) ? 16'hffff : ((16'd1 << cnt) - 16'd1));
      if (free_slabs[z] < n || avail == 0) return -1;
      g = trail0({48'd0, avail});
      if (n == 1) return int'(g * 64 + trail0(~words[z * ZONE_WORDS + g]));
      for (; g < cnt; g++) begin
        w = words[z * ZONE_WORDS + g];
        if (w == '1) continue;
        if (n <= 64) begin
          s = first_run(~w, n);
          if (s >= 0) return int'(g * 64) + s;
          if (g + 1 < cnt &&
              lead0(w) + trail0(words[z * ZONE_WORDS + g + 1]) >= n)
            return int'(g * 64 + 64 - lead0(w));
        end else begin
          top = lead0(w);
          total = top;
          for (int unsigned j = g + 1; j < cnt; j++) begin
            sp = trail0(words[z * ZONE_WORDS + j]);
            total += sp;
            if (sp < 64 || total >= n) break;
          end
          if (total >= n) return int'(g * 64 + 64 - top);
        end
      end
      return -1;
    endfunction

    function void note_request(in_item_t req);
      out_item_t r;
      int pos;
      int unsigned z, n, zg, zl;
      r = '0;
      n = req.run_len;
      if (req.operation == OP_ALLOC) begin
        pos = -1;
        z = 0;
        if (n != 0) begin
          for (z = 0; z < open_zones; z++) begin
            pos = place_in_zone(z, n);
            if (pos >= 0) break;
          end
          if (pos < 0) begin
            zg = cfg_groups == 0 ? 1 : (cfg_groups > 16 ? 16 : cfg_groups);
            zl = cfg_limit > NZONES ? NZONES : cfg_limit;
            if (open_zones < zl && n <= zg * 64) begin
              z = open_zones++;
              for (int g = 0; g < ZONE_WORDS; g++) words[z * ZONE_WORDS + g] = '0;
              groups[z] = zg;
              free_slabs[z] = zg * 64;
              full_map[z] = '0;
              empty_map[z] = (zg >= 16) ? 16'hffff : ((16'd1 << zg) - 16'd1);
              pos = 0;
            end
          end
        end
        if (pos < 0) r.status = ST_NO_SPACE;
        else begin
          set_run(z, pos, n, 1'b1);
          r.status = ST_DONE;
          r.result_zone = z[1:0];
          r.result_offset = pos[9:0];
          r.zone_free_slabs = free_slabs[z][10:0];
        end
      end else begin
        z = req.zone_id;
        if (n == 0 || z >= open_zones || req.first_slab + n > groups[z] * 64)
          r.status = ST_BAD_FREE;
        else begin
          set_run(z, req.first_slab, n, 1'b0);
          r.status = ST_DONE;
          r.result_zone = req.zone_id;
          r.result_offset = req.first_slab;
          r.zone_free_slabs = free_slabs[z][10:0];
        end
      end
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("%0t: mismatch: %s", $time, what);
      errors++;
    endtask

    task check_response(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected response %p", got));
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.result_zone !== exp.result_zone)
        report($sformatf("zone %0d, expected %0d", got.result_zone, exp.result_zone));
      if (got.result_offset !== exp.result_offset)
        report($sformatf("offset %0d, expected %0d", got.result_offset, exp.result_offset));
      if (got.zone_free_slabs !== exp.zone_free_slabs)
        report($sformatf("free slabs %0d, expected %0d",
                         got.zone_free_slabs, exp.zone_free_slabs));
    endtask
  endclass
endpackage
`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the slab run allocator testbench: stimulus, response sink, watchdog.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import bsra_pkg::*;
  import slab_alloc_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bsra_in_if in_ch();
  bsra_out_if out_ch();
  bsra_cfg_if cfg_ch();

  slab_alloc_scoreboard board = new();
  int idle_cycles = 0;
  bit steady_sink = 0;

  // Live allocations, for freeing runs that were actually taken.
  logic [1:0] live_zone[$];
  logic [9:0] live_off[$];
  logic [10:0] live_len[$];

  bitmap_slab_run_allocator_unit u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ZONE_GROUPS;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) idle_cycles <= 0;
    else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
             || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Response sink with random stalls.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = steady_sink ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      board.check_response(out_ch.data);
      @(negedge clk);
    end
  end

  task automatic send_request(in_item_t req, int gap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request(req);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic alloc(int unsigned n, int gap);
    in_item_t r;
    r.operation = OP_ALLOC;
    r.run_len = 11'(n);
    r.zone_id = 2'($urandom);
    r.first_slab = 10'($urandom);
    send_request(r, gap);
  endtask

  task automatic free_run(logic [1:0] z, logic [9:0] off, logic [10:0] n, int gap);
    in_item_t r;
    r.operation = OP_FREE;
    r.run_len = n;
    r.zone_id = z;
    r.first_slab = off;
    send_request(r, gap);
  endtask

  // Mirror allocations from predicted results so frees target real runs.
  task automatic alloc_tracked(int unsigned n, int gap);
    out_item_t e;
    alloc(n, gap);
    e = board.pending[board.pending.size() - 1];
    if (e.status == ST_DONE && n != 0) begin
      live_zone.push_back(e.result_zone);
      live_off.push_back(e.result_offset);
      live_len.push_back(11'(n));
    end
  endtask

  function automatic int unsigned rand_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 1;
    if (p < 75) return $urandom_range(2, 64);
    if (p < 95) return $urandom_range(65, 300);
    return $urandom_range(0, 2047);
  endfunction

  initial begin
    int unsigned k, i, gap;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes and special cases at reset settings.
    alloc_tracked(0, 0);
    alloc_tracked(1, 0);
    alloc_tracked(64, 1);
    alloc_tracked(63, 0);
    alloc_tracked(2, 0);
    alloc_tracked(130, 0);
    alloc_tracked(1024, 0);
    alloc_tracked(1025, 0);
    alloc_tracked(2047, 0);
    free_run(2'd0, 10'd0, 11'd0, 0);
    free_run(2'd3, 10'd0, 11'd1, 0);
    free_run(2'd0, 10'd1023, 11'd2, 0);
    free_run(2'd0, 10'd1, 11'd63, 0);
    free_run(2'd0, 10'd0, 11'd200, 2);
    free_run(2'd0, 10'd0, 11'd200, 0);
    free_run(2'd0, 10'd1023, 11'd1, 0);
    alloc_tracked(100, 0);
    alloc_tracked(1, 0);
    drain();

    write_reg(REG_ZONE_GROUPS, 5'd0);
    write_reg(REG_ZONE_LIMIT, 5'd0);
    alloc_tracked(1, 0);
    drain();
    write_reg(REG_ZONE_LIMIT, 5'd7);
    write_reg(REG_ZONE_GROUPS, 5'd31);
    alloc_tracked(65, 0);
    alloc_tracked(1024, 0);
    drain();

    // Random phases under varied settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ZONE_GROUPS, ph == 0 ? 5'd1 : (ph == 1 ? 5'd16 : 5'($urandom)));
      write_reg(REG_ZONE_LIMIT, ph == 0 ? 5'd1 : {2'b0, 3'($urandom)});
      steady_sink = (ph == 3);
      for (i = 0; i < 180; i++) begin
        gap = (ph == 3) ? 0 : $urandom_range(0, 11);
        k = $urandom_range(0, 99);
        if (k < 50) alloc_tracked(rand_len(), gap);
        else if (k < 85 && live_zone.size() != 0) begin
          k = $urandom_range(0, live_zone.size() - 1);
          free_run(live_zone[k], live_off[k], live_len[k], gap);
          live_zone.delete(k);
          live_off.delete(k);
          live_len.delete(k);
        end else
          free_run(2'($urandom), 10'($urandom), 11'(rand_len()), gap);
      end
      drain();
    end
    steady_sink = 0;
    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/bsra_pkg.sv
hdl/bsra_in_if.sv
hdl/bsra_out_if.sv
hdl/bsra_cfg_if.sv
hdl/bsra_ctrl.sv
hdl/bsra_dp.sv
hdl/bitmap_slab_run_allocator_unit.sv
tb/slab_alloc_scoreboard.sv
tb/testbench.sv
